>>> sv/gkia_pkg.sv
// ----------------------------------------------------------------------------
// gkia_pkg: shared types and constants for the group key index assigner
// Holds table sizing, transaction payloads and the probe handed along the
// chain of table cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gkia_pkg;

	// Table sizing
	localparam int MAX_GROUPS = 256;
	localparam int KEY_WIDTH  = 64;
	localparam int IDX_W      = (MAX_GROUPS > 2) ? $clog2(MAX_GROUPS) : 1;

	// Field widths fixed by the interface
	localparam int KEY_FIELD_W = 64;
	localparam int GRP_FIELD_W = 8;

	// Input transaction
	typedef struct packed {
		logic                   start_query;
		logic [KEY_FIELD_W-1:0] key_value;
	} row_t;

	// Output transaction
	typedef struct packed {
		logic [GRP_FIELD_W-1:0] group_number;
		logic                   new_group;
		logic                   table_overflow;
	} grp_t;

	// Lookup probe passed from cell to cell
	typedef struct packed {
		logic                   live;
		logic                   done;
		logic                   fresh;
		logic [GRP_FIELD_W-1:0] num;
		logic [KEY_WIDTH-1:0]   key;
	} probe_t;

endpackage

`default_nettype wire

>>> sv/gkia_cell.sv
// ----------------------------------------------------------------------------
// gkia_cell: one table entry of the group key index assigner
// Stores one key with its valid bit, compares the passing probe against it,
// claims the entry for a new key and hands the probe to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gkia_cell
	import gkia_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              clr,
	input  wire logic [IDX_W-1:0]  idx,
	input  wire probe_t            probe_in,
	output probe_t                 probe_out
);

	logic                         valid_q;
	logic [KEY_WIDTH-1:0]         key_q;
	probe_t                       probe_q;
	probe_t                       probe_d;
	logic                         valid_eff;
	logic                         insert;
	logic [IDX_W+GRP_FIELD_W-1:0] idx_ext;

	assign idx_ext   = {{GRP_FIELD_W{1'b0}}, idx};
	assign valid_eff = valid_q & ~clr;

	// Compare or claim this entry for a probe still searching
	always_comb begin
		probe_d = probe_in;
		insert  = 1'b0;
		if (probe_in.live && !probe_in.done) begin
			if (valid_eff && (key_q == probe_in.key)) begin
				probe_d.done  = 1'b1;
				probe_d.fresh = 1'b0;
				probe_d.num   = idx_ext[GRP_FIELD_W-1:0];
			end else if (!valid_eff) begin
				insert        = 1'b1;
				probe_d.done  = 1'b1;
				probe_d.fresh = 1'b1;
				probe_d.num   = idx_ext[GRP_FIELD_W-1:0];
			end
		end
	end

	// Valid bit: clear on query start, set when claimed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en && insert) begin
			valid_q <= 1'b1;
		end else if (clr) begin
			valid_q <= 1'b0;
		end
	end

	// Stored key
	always_ff @(posedge clk) begin
		if (en && insert) begin
			key_q <= probe_in.key;
		end
	end

	// Advance the probe to the neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= '0;
		end else if (en) begin
			probe_q <= probe_d;
		end
	end

	assign probe_out = probe_q;

endmodule

`default_nettype wire

>>> sv/group_key_index_assigner.sv
// ----------------------------------------------------------------------------
// group_key_index_assigner: dense group numbering of packed group-by keys
// A chain of table cells, one per group; a probe walks the chain, hits the
// entry holding its key or claims the first free one, and leaves the end
// as the result transaction.
// ----------------------------------------------------------------------------
//  channel | valid      | stall      | payload
//  --------+------------+------------+-------------------------------------
//  row     | row_valid  | row_stall  | row : start_query, key_value
//  grp     | grp_valid  | grp_stall  | grp : group_number, new_group,
//          |            |            |       table_overflow
//
//  One row at a time: the probe moves one cell per cycle, unless the chain
//  is held, through all MAX_GROUPS cells and then into the output register;
//  the next row can be taken in the same cycle as the result is offered.
//  Reset clears all valid bits at once; no sweep is needed.
//  A row may be taken while a result waits; if the next result reaches the
//  end of the chain while the output is still stalled, the chain holds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module group_key_index_assigner
	import gkia_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic row_valid,
	output logic      row_stall,
	input  wire row_t row,
	output logic      grp_valid,
	input  wire logic grp_stall,
	output grp_t      grp
);

	probe_t chain [MAX_GROUPS+1];
	probe_t last;
	logic   busy_q;
	logic   grp_valid_q;
	grp_t   grp_q;
	logic   accept;
	logic   en;
	logic   clr;

	assign accept    = row_valid & ~row_stall;
	assign row_stall = busy_q;
	assign clr       = accept & row.start_query;
	assign last      = chain[MAX_GROUPS];

	// Hold the chain while a finished probe cannot leave
	assign en = ~(last.live & grp_valid_q & grp_stall);

	// Launch the probe into the first cell
	always_comb begin
		chain[0]       = '0;
		chain[0].live  = accept;
		chain[0].key   = row.key_value[KEY_WIDTH-1:0];
	end

	// Row of table cells
	for (genvar i = 0; i < MAX_GROUPS; i++) begin : g_cell
		gkia_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.clr       (clr),
			.idx       (IDX_W'(i)),
			.probe_in  (chain[i]),
			.probe_out (chain[i+1])
		);
	end

	// Busy from accept until the probe leaves the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (en && last.live) begin
			busy_q <= 1'b0;
		end
	end

	// Output register: load the finished probe, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_valid_q <= 1'b0;
		end else if (en && last.live) begin
			grp_valid_q <= 1'b1;
		end else if (!grp_stall) begin
			grp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && last.live) begin
			if (last.done) begin
				grp_q.group_number   <= last.num;
				grp_q.new_group      <= last.fresh;
				grp_q.table_overflow <= 1'b0;
			end else begin
				grp_q.group_number   <= '0;
				grp_q.new_group      <= 1'b1;
				grp_q.table_overflow <= 1'b1;
			end
		end
	end

	assign grp_valid = grp_valid_q;
	assign grp       = grp_q;

endmodule

`default_nettype wire

>>> test/group_key_index_assigner_tb.sv
// ----------------------------------------------------------------------------
// group_key_index_assigner_tb: self-checking bench for the group key indexer
// Streams row keys through the block. A local copy of the group table
// predicts each group number, new-group flag and overflow flag. Directed rows
// cover edge keys and query restarts. A full-table pass drives overflow, a
// long output hold backs the block up, and random queries with repeated keys
// fill most of the run. Both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module group_key_index_assigner_tb;
	import gkia_pkg::*;

	localparam int CYCLE_LIMIT   = 3_000_000;
	localparam int RANDOM_ROWS   = 1100;
	localparam int SETTLE_CYCLES = MAX_GROUPS + 16;
	localparam logic [KEY_FIELD_W-1:0] KEY_MASK =
		(KEY_WIDTH >= KEY_FIELD_W) ? '1 : ((64'd1 << KEY_WIDTH) - 64'd1);

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic row_valid = 1'b0;
	logic row_stall;
	row_t row = '0;
	logic grp_valid;
	logic grp_stall = 1'b0;
	grp_t grp;

	// Local group table
	logic [KEY_FIELD_W-1:0] known_keys [MAX_GROUPS];
	logic                   key_live   [MAX_GROUPS] = '{default: 1'b0};
	int                     live_count = 0;

	grp_t        expected_groups [$];
	int          mismatches      = 0;
	int          cycle_count     = 0;
	bit          row_gaps_on     = 1'b1;
	bit          grp_stalls_on   = 1'b1;
	int unsigned grp_hold_cycles = 0;

	group_key_index_assigner uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.row_valid (row_valid),
		.row_stall (row_stall),
		.row       (row),
		.grp_valid (grp_valid),
		.grp_stall (grp_stall),
		.grp       (grp)
	);

	always #5 clk = ~clk;

	// Look up or claim the group for one row, updating the local table
	function automatic grp_t assign_group(input row_t r);
		logic [KEY_FIELD_W-1:0] k;
		grp_t                   g;
		int                     hit;
		int                     i;
		k   = r.key_value & KEY_MASK;
		g   = '0;
		hit = -1;
		if (r.start_query) begin
			for (i = 0; i < MAX_GROUPS; i++)
				key_live[i] = 1'b0;
			live_count = 0;
		end
		for (i = 0; i < MAX_GROUPS; i++)
			if (hit < 0 && key_live[i] && known_keys[i] == k)
				hit = i;
		if (hit >= 0) begin
			g.group_number = GRP_FIELD_W'(hit);
		end else if (live_count < MAX_GROUPS) begin
			known_keys[live_count] = k;
			key_live[live_count]   = 1'b1;
			g.group_number         = GRP_FIELD_W'(live_count);
			g.new_group            = 1'b1;
			live_count++;
		end else begin
			g.new_group      = 1'b1;
			g.table_overflow = 1'b1;
		end
		return g;
	endfunction

	// Offer one row after a random gap; record its expected group on accept
	task automatic send_row(input logic start, input logic [KEY_FIELD_W-1:0] key);
		row_t        item;
		int unsigned gap;
		item.start_query = start;
		item.key_value   = key;
		gap = row_gaps_on ? $urandom_range(0, 9) : 0;
		if (gap != 0) begin
			row_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		row_valid <= 1'b1;
		row       <= item;
		do @(posedge clk); while (row_stall);
		expected_groups.insert(expected_groups.size(), assign_group(item));
	endtask

	// Drop valid and hold until every pending group number has come back
	task automatic wait_drained();
		row_valid <= 1'b0;
		do @(posedge clk); while (expected_groups.size() != 0);
	endtask

	function automatic logic [KEY_FIELD_W-1:0] random_key();
		return {$urandom, $urandom};
	endfunction

	// Drive output stall: random wait per transaction, plus any long hold request
	initial begin : grp_stall_drive
		int unsigned stall_n;
		@(posedge arst_n);
		forever begin
			stall_n         = grp_hold_cycles;
			grp_hold_cycles = 0;
			if (grp_stalls_on)
				stall_n += $urandom_range(0, 9);
			if (stall_n != 0) begin
				grp_stall <= 1'b1;
				repeat (stall_n) @(posedge clk);
			end
			grp_stall <= 1'b0;
			do @(posedge clk);
			while (!(grp_valid && !grp_stall) && grp_hold_cycles == 0);
		end
	end

	// Compare each result transaction against the oldest expectation
	always @(posedge clk) begin
		grp_t want;
		if (grp_valid && !grp_stall) begin
			if (expected_groups.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual num=%0d new=%0b ovf=%0b",
					$time, grp.group_number, grp.new_group, grp.table_overflow);
				mismatches++;
			end else begin
				want = expected_groups.pop_front();
				if (grp.group_number !== want.group_number) begin
					$display("%0t: group_number: expected %0d, actual %0d",
						$time, want.group_number, grp.group_number);
					mismatches++;
				end
				if (grp.new_group !== want.new_group) begin
					$display("%0t: new_group: expected %0b, actual %0b",
						$time, want.new_group, grp.new_group);
					mismatches++;
				end
				if (grp.table_overflow !== want.table_overflow) begin
					$display("%0t: table_overflow: expected %0b, actual %0b",
						$time, want.table_overflow, grp.table_overflow);
					mismatches++;
				end
			end
		end
	end

	// End the run if it hangs
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("group_key_index_assigner: mismatch");
		$finish;
	end

	// Edge keys, hits, misses and query restarts
	task automatic test_first_rows();
		send_row(1'b0, 64'h0);
		send_row(1'b0, 64'h0);
		send_row(1'b0, '1);
		send_row(1'b0, 64'h8000_0000_0000_0000);
		send_row(1'b0, 64'h1);
		send_row(1'b0, 64'hAAAA_AAAA_AAAA_AAAA);
		send_row(1'b0, 64'h5555_5555_5555_5555);
		send_row(1'b0, '1);
		send_row(1'b0, 64'h1);
		send_row(1'b1, 64'h5555_5555_5555_5555);
		send_row(1'b0, 64'h0);
		send_row(1'b0, 64'hAAAA_AAAA_AAAA_AAAA);
		send_row(1'b0, 64'h5555_5555_5555_5555);
		send_row(1'b1, 64'h0);
		send_row(1'b1, 64'h0);
		send_row(1'b1, 64'hFFFF_FFFF_0000_0000);
		send_row(1'b0, 64'h0000_0000_FFFF_FFFF);
		send_row(1'b0, 64'hFFFF_FFFF_0000_0000);
		send_row(1'b0, 64'h0000_0000_FFFF_FFFF);
		wait_drained();
	endtask

	// Fill every entry, then push new keys into the full table
	task automatic test_full_table();
		logic [KEY_FIELD_W-1:0] first_key;
		logic [KEY_FIELD_W-1:0] last_key;
		logic [KEY_FIELD_W-1:0] spill_key;
		int                     i;
		for (i = 0; i < MAX_GROUPS; i++) begin
			last_key = {48'(random_key() >> 16), 16'(i)};
			if (i == 0)
				first_key = last_key;
			send_row(i == 0, last_key);
		end
		spill_key = random_key();
		send_row(1'b0, spill_key);
		send_row(1'b0, spill_key);
		send_row(1'b0, last_key);
		send_row(1'b0, ~spill_key);
		send_row(1'b0, first_key);
		send_row(1'b1, spill_key);
		send_row(1'b0, first_key);
		wait_drained();
	endtask

	// Hold the output long enough that the block stalls its input
	task automatic test_output_hold();
		int i;
		row_gaps_on     = 1'b0;
		grp_hold_cycles = 4 * MAX_GROUPS + 200;
		for (i = 0; i < 8; i++)
			send_row(i == 0, (i % 3 == 2) ? 64'h0 : random_key());
		wait_drained();
		row_gaps_on = 1'b1;
	endtask

	// Random queries: repeated keys from a small pool, fresh keys, stray restarts
	task automatic test_random_queries();
		logic [KEY_FIELD_W-1:0] key_pool [32];
		int                     rows_sent;
		int                     query_len;
		int                     pool_n;
		int                     fresh_pct;
		int                     pick;
		int                     i;
		logic                   start;
		rows_sent = 0;
		while (rows_sent < RANDOM_ROWS) begin
			pick = $urandom_range(0, 99);
			if (pick < 85)
				query_len = $urandom_range(1, 40);
			else if (pick < 95)
				query_len = $urandom_range(41, 200);
			else
				query_len = $urandom_range(MAX_GROUPS + 1, MAX_GROUPS + 40);
			fresh_pct     = (query_len > MAX_GROUPS) ? 90 : 25;
			pool_n        = $urandom_range(1, 32);
			row_gaps_on   = ($urandom_range(0, 3) != 0);
			grp_stalls_on = ($urandom_range(0, 3) != 0);
			for (i = 0; i < pool_n; i++)
				key_pool[i] = ($urandom_range(0, 3) == 0) ?
					KEY_FIELD_W'($urandom_range(0, 15)) : random_key();
			for (i = 0; i < query_len; i++) begin
				if (i == 0)
					start = ($urandom_range(0, 9) != 0);
				else
					start = ($urandom_range(0, 99) < 3);
				if ($urandom_range(0, 99) < fresh_pct)
					send_row(start, random_key());
				else
					send_row(start, key_pool[$urandom_range(0, pool_n - 1)]);
				rows_sent++;
			end
			if ($urandom_range(0, 5) == 0)
				wait_drained();
		end
		row_gaps_on   = 1'b1;
		grp_stalls_on = 1'b1;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_first_rows();
		test_full_table();
		test_output_hold();
		test_random_queries();

		// Let the chain settle and catch any stray result
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_groups.size() != 0) begin
			$display("%0t: %0d expected results never arrived",
				$time, expected_groups.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("group_key_index_assigner: match");
		else
			$display("group_key_index_assigner: mismatch");
		$finish;
	end

endmodule

`default_nettype wire

>>> filelist.f
sv/gkia_pkg.sv
sv/gkia_cell.sv
sv/group_key_index_assigner.sv
test/group_key_index_assigner_tb.sv
